// File: src/utc_to_local_time_eu_dst_core_defines.svh
// assertion macros for the utc to local time core
`ifndef UTC_TO_LOCAL_TIME_EU_DST_CORE_DEFINES_SVH
`define UTC_TO_LOCAL_TIME_EU_DST_CORE_DEFINES_SVH

// checked after reset has been released
`define UTCL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked also while reset is held
`define UTCL_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/utcl_pkg.sv
// shared types and calendar functions for the utc to local time core
package utcl_pkg;

  localparam int unsigned HoursPerDay = 24;
  localparam int unsigned SundayCode = 6;

  typedef enum logic {
    REG_UTC_OFFSET = 1'b0,
    REG_DST_ENABLE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [2:0]  weekday;
  } date_t;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    date_t      date;
  } stamp_t;

  typedef struct packed {
    stamp_t stamp;
    logic   dst_applied;
  } result_t;

  function automatic logic leap_year(logic [11:0] y);
    logic [9:0]  k;
    logic [15:0] prod;
    logic [5:0]  q;
    logic [10:0] q25;
    logic [9:0]  rem;
    logic        century;
    k = y[11:2];
    // k / 25 through a reciprocal, exact for every 10 bit k
    prod = 16'(k) * 16'd41;
    q = prod[15:10];
    q25 = 11'(q) * 11'd25;
    rem = k - q25[9:0];
    century = (rem == 10'd0);
    return (y[1:0] == 2'd0) && (!century || (q[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] days_in_month(logic [3:0] m, logic [11:0] y);
    logic [4:0] len;
    len = 5'd31;
    if (m == 4'd2) begin
      len = leap_year(y) ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end
    return len;
  endfunction

  function automatic date_t move_day(date_t d, logic fwd, logic bwd);
    date_t r;
    r = d;
    if (fwd) begin
      r.weekday = (d.weekday == 3'(SundayCode)) ? 3'd0 : d.weekday + 3'd1;
      if (d.day >= days_in_month(d.month, d.year)) begin
        r.day = 5'd1;
        if (d.month >= 4'd12) begin
          r.month = 4'd1;
          r.year = d.year + 12'd1;
        end else begin
          r.month = d.month + 4'd1;
        end
      end else begin
        r.day = d.day + 5'd1;
      end
    end else if (bwd) begin
      r.weekday = (d.weekday == 3'd0) ? 3'(SundayCode) : d.weekday - 3'd1;
      if (d.day <= 5'd1) begin
        if (d.month <= 4'd1) begin
          r.month = 4'd12;
          r.year = d.year - 12'd1;
        end else begin
          r.month = d.month - 4'd1;
        end
        r.day = days_in_month(r.month, r.year);
      end else begin
        r.day = d.day - 5'd1;
      end
    end
    return r;
  endfunction

endpackage

// File: src/utcl_offset_stage.sv
// input clamping, hour offset and first day carry
module utcl_offset_stage (
  input  utcl_pkg::stamp_t  utc,
  input  logic signed [4:0] utc_offset_hours,
  output utcl_pkg::stamp_t  shifted
);
  import utcl_pkg::*;

  date_t             clamped;
  logic [4:0]        len;
  logic signed [6:0] hour_sum;
  logic signed [6:0] hour_wrap;
  logic              fwd;
  logic              bwd;

  always_comb begin
    clamped = utc.date;
    if (utc.date.month < 4'd1) begin
      clamped.month = 4'd1;
    end else if (utc.date.month > 4'd12) begin
      clamped.month = 4'd12;
    end
    len = days_in_month(clamped.month, clamped.year);
    if (utc.date.day < 5'd1) begin
      clamped.day = 5'd1;
    end else if (utc.date.day > len) begin
      clamped.day = len;
    end
    if (utc.date.weekday == 3'd7) begin
      clamped.weekday = 3'd0;
    end

    hour_sum = signed'({2'b00, utc.hour}) + 7'(utc_offset_hours);
    fwd = (hour_sum >= 7'sd24);
    bwd = (hour_sum < 7'sd0);
    hour_wrap = hour_sum;
    if (fwd) begin
      hour_wrap = hour_sum - 7'(HoursPerDay);
    end else if (bwd) begin
      hour_wrap = hour_sum + 7'(HoursPerDay);
    end

    shifted.second = utc.second;
    shifted.minute = utc.minute;
    shifted.hour = hour_wrap[4:0];
    shifted.date = move_day(clamped, fwd, bwd);
  end

endmodule

// File: src/utcl_dst_stage.sv
// eu summer time test and second day carry
module utcl_dst_stage (
  input  utcl_pkg::stamp_t  shifted,
  input  logic              dst_enable,
  output utcl_pkg::result_t result
);
  import utcl_pkg::*;

  logic       past_switch;
  logic       summer;
  logic       applied;
  logic       fwd;
  logic [5:0] switch_day;

  always_comb begin
    // on a late sunday the switch happens at the hour, otherwise it is a date test
    switch_day = 6'd25 + 6'(shifted.date.weekday);
    if (shifted.date.weekday == 3'(SundayCode) && shifted.date.day >= 5'd25) begin
      past_switch = (shifted.hour > 5'd2);
    end else begin
      past_switch = (6'(shifted.date.day) > switch_day);
    end

    case (shifted.date.month)
      4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9: summer = 1'b1;
      4'd3:    summer = past_switch;
      4'd10:   summer = !past_switch;
      default: summer = 1'b0;
    endcase

    applied = dst_enable && summer;
    fwd = applied && (shifted.hour == 5'(HoursPerDay - 1));

    result.stamp = shifted;
    result.dst_applied = applied;
    if (applied) begin
      result.stamp.hour = fwd ? 5'd0 : shifted.hour + 5'd1;
    end
    result.stamp.date = move_day(shifted.date, fwd, 1'b0);
  end

endmodule

// File: src/utc_to_local_time_eu_dst_core.sv
// top level of the utc to local time converter with eu summer time
//
// Input stream s_*: one utc calendar time per beat. Output stream m_*: one local
// time per input beat, in the same order.
// Config: cfg_we writes cfg_data into register cfg_index (0 utc offset, signed
// 5 bit; 1 summer time enable). Write only while no beat is in flight.
// Throughput: one beat per cycle while m_tready is high. A beat passes the first
// register, which holds the offset and first day carry, then the output register,
// which holds the summer time step and second carry.
// Reset: both pipeline registers empty, offset 0, summer time off.
// Stall: while m_tready is low a valid output holds; the first register
// still takes a beat if it is empty, then s_tready drops until the output drains.
module utc_to_local_time_eu_dst_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // second, minute, hour, day, month, year, weekday, zero fill
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // second, minute, hour, day, month, year, weekday, dst_applied, zero fill
  output logic [47:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);
  import utcl_pkg::*;

  logic signed [4:0] utc_offset_hours;
  logic              dst_enable;

  stamp_t  utc_in;
  stamp_t  shifted_next;
  stamp_t  shifted;
  logic    shifted_valid;
  result_t result_next;
  result_t result;
  logic    out_ready;

  assign utc_in.second = s_tdata[5:0];
  assign utc_in.minute = s_tdata[11:6];
  assign utc_in.hour = s_tdata[16:12];
  assign utc_in.date.day = s_tdata[21:17];
  assign utc_in.date.month = s_tdata[25:22];
  assign utc_in.date.year = s_tdata[37:26];
  assign utc_in.date.weekday = s_tdata[40:38];

  assign out_ready = !m_tvalid || m_tready;
  assign s_tready = !shifted_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      utc_offset_hours <= 5'sd0;
      dst_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_UTC_OFFSET: utc_offset_hours <= signed'(cfg_data);
        REG_DST_ENABLE: dst_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  utcl_offset_stage u_offset (
    .utc              (utc_in),
    .utc_offset_hours (utc_offset_hours),
    .shifted          (shifted_next)
  );

  utcl_dst_stage u_dst (
    .shifted    (shifted),
    .dst_enable (dst_enable),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      shifted_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_ready) begin
        m_tvalid <= shifted_valid;
      end
      if (s_tready) begin
        shifted_valid <= s_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      shifted <= shifted_next;
    end
    if (out_ready && shifted_valid) begin
      result <= result_next;
    end
  end

  assign m_tdata = {6'd0, result.dst_applied, result.stamp.date.weekday,
                    result.stamp.date.year, result.stamp.date.month,
                    result.stamp.date.day, result.stamp.hour,
                    result.stamp.minute, result.stamp.second};

`include "utc_to_local_time_eu_dst_core_defines.svh"

  `UTCL_ASSERT(a_hour_range, m_tvalid |-> (m_tdata[16:12] < 5'd24), "local hour out of range")
  `UTCL_ASSERT(a_dst_needs_enable, (m_tvalid && m_tdata[41]) |-> dst_enable,
               "dst hour added while disabled")
  `UTCL_ASSERT(a_date_range,
               m_tvalid |-> (m_tdata[21:17] != 5'd0 && m_tdata[40:38] != 3'd7 &&
                             m_tdata[25:22] != 4'd0),
               "local date field out of range")
  `UTCL_ASSERT(a_stage_kept, (shifted_valid && !out_ready) |=> shifted_valid,
               "stalled item dropped from first register")
  `UTCL_ASSERT_ALWAYS(a_reset_empty, rst |=> (!m_tvalid && !shifted_valid),
                      "pipeline not empty after reset")

endmodule

// File: bench/utc_to_local_time_eu_dst_core_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the utc to local time converter with eu summer time
module utc_to_local_time_eu_dst_core_test;
  import utcl_pkg::*;

  localparam int Sunday = 6;

  typedef struct packed {
    logic [6:0]  pad;
    logic [2:0]  weekday;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } utc_beat_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic        dst_applied;
    logic [2:0]  weekday;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } local_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [4:0]  cfg_data = '0;

  local_beat_t pending_local[$];
  local_beat_t oldest_local;
  int          offset_hours = 0;
  bit          dst_on = 1'b0;
  bit          gaps_off = 1'b0;
  int          stall_left = 0;
  int          mismatches = 0;
  int          beats_checked = 0;
  int          summer_beats = 0;
  int          settings_used = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  utc_to_local_time_eu_dst_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic int unsigned month_len(int unsigned m, int unsigned y);
    bit leap;
    leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    if (m == 2) return leap ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic void step_date(inout int unsigned d, inout int unsigned m,
                                    inout int unsigned y, inout int unsigned wd,
                                    input int dir);
    if (dir > 0) begin
      wd = (wd + 1) % 7;
      if (d >= month_len(m, y)) begin
        d = 1;
        if (m >= 12) begin
          m = 1;
          y = (y + 1) & 'hFFF;
        end else begin
          m = m + 1;
        end
      end else begin
        d = d + 1;
      end
    end else if (dir < 0) begin
      wd = (wd + 6) % 7;
      if (d <= 1) begin
        if (m <= 1) begin
          m = 12;
          y = (y + 'hFFF) & 'hFFF;
        end else begin
          m = m - 1;
        end
        d = month_len(m, y);
      end else begin
        d = d - 1;
      end
    end
  endfunction

  function automatic int fold_hour(inout int h);
    if (h >= 24) begin
      h = h - 24;
      return 1;
    end
    if (h < 0) begin
      h = h + 24;
      return -1;
    end
    return 0;
  endfunction

  // switch sunday of a 31 day month already passed
  function automatic bit after_last_sunday(int unsigned d, int unsigned wd, int h);
    int to_last;
    int to_sunday;
    to_last = 31 - int'(d);
    to_sunday = Sunday - int'(wd);
    if (to_sunday == 0 && to_last < 7) return h > 2;
    return to_last < to_sunday;
  endfunction

  function automatic local_beat_t local_time_of(utc_beat_t u, int offset, bit dst);
    local_beat_t r;
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned wd;
    int h;
    int carry;
    bit summer;
    m = u.month;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    y = u.year;
    d = u.day;
    if (d < 1) d = 1;
    if (d > month_len(m, y)) d = month_len(m, y);
    wd = u.weekday % 7;
    h = int'(u.hour) + offset;
    carry = fold_hour(h);
    step_date(d, m, y, wd, carry);
    summer = 1'b0;
    if (dst) begin
      if (m > 3 && m < 10) summer = 1'b1;
      else if (m == 3) summer = after_last_sunday(d, wd, h);
      else if (m == 10) summer = !after_last_sunday(d, wd, h);
    end
    if (summer) begin
      h = h + 1;
      carry = fold_hour(h);
      step_date(d, m, y, wd, carry);
    end
    r = '0;
    r.second = u.second;
    r.minute = u.minute;
    r.hour = 5'(h);
    r.day = 5'(d);
    r.month = 4'(m);
    r.year = 12'(y);
    r.weekday = 3'(wd);
    r.dst_applied = summer;
    return r;
  endfunction

  function automatic logic [11:0] field_of(logic [47:0] d, int i);
    case (i)
      0: return 12'(d[5:0]);
      1: return 12'(d[11:6]);
      2: return 12'(d[16:12]);
      3: return 12'(d[21:17]);
      4: return 12'(d[25:22]);
      5: return d[37:26];
      6: return 12'(d[40:38]);
      default: return 12'(d[41]);
    endcase
  endfunction

  function automatic string field_name(int i);
    case (i)
      0: return "second";
      1: return "minute";
      2: return "hour";
      3: return "day";
      4: return "month";
      5: return "year";
      6: return "weekday";
      default: return "dst_applied";
    endcase
  endfunction

  function automatic utc_beat_t utc_at(int sec, int mnt, int hr, int dy, int mon, int yr,
                                       int wd);
    utc_beat_t r;
    r = '0;
    r.second = 6'(sec);
    r.minute = 6'(mnt);
    r.hour = 5'(hr);
    r.day = 5'(dy);
    r.month = 4'(mon);
    r.year = 12'(yr);
    r.weekday = 3'(wd);
    return r;
  endfunction

  function automatic int idle_cycles();
    int r;
    if (gaps_off) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic utc_beat_t random_utc();
    utc_beat_t u;
    int kind;
    int unsigned y;
    kind = $urandom_range(0, 99);
    y = $urandom_range(1970, 2225);
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: y = 2000;
        1: y = 2100;
        2: y = 2200;
        default: y = 2024;
      endcase
    end
    u = utc_at($urandom_range(0, 59), $urandom_range(0, 59), $urandom_range(0, 23), 1,
               $urandom_range(1, 12), y, $urandom_range(0, 6));
    u.day = 5'($urandom_range(1, month_len(u.month, y)));
    if (kind < 10) begin
      u = 48'({$urandom(), $urandom()}) & 48'h01FF_FFFF_FFFF;
    end else if (kind < 45) begin
      // days 22 to 31 of march or october, local hour near the switch
      u.month = $urandom_range(0, 1) ? 4'd3 : 4'd10;
      u.day = 5'($urandom_range(22, 31));
      u.weekday = ($urandom_range(0, 2) == 0) ? 3'(Sunday) : 3'($urandom_range(0, 6));
      u.hour = 5'((int'($urandom_range(0, 4)) - offset_hours + 48) % 24);
    end else if (kind < 65) begin
      if ($urandom_range(0, 3) == 0) u.month = $urandom_range(0, 1) ? 4'd12 : 4'd1;
      u.day = $urandom_range(0, 1) ? 5'(month_len(u.month, y)) : 5'd1;
      u.hour = $urandom_range(0, 1) ? 5'($urandom_range(0, 2)) : 5'($urandom_range(21, 23));
    end
    return u;
  endfunction

  task automatic send_utc(input utc_beat_t u);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= u;
    do @(posedge clk); while (!s_tready);
    pending_local.push_back(local_time_of(u, offset_hours, dst_on));
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_local.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t index, input logic [4:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (index == REG_UTC_OFFSET) offset_hours = $signed(value);
    else dst_on = value[0];
  endtask

  task automatic configure(input int offset, input bit dst);
    settle();
    write_reg(REG_UTC_OFFSET, 5'(offset));
    write_reg(REG_DST_ENABLE, 5'(dst));
    settings_used++;
  endtask

  // output side stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (gaps_off || $urandom_range(0, 99) < 65) begin
      m_tready <= 1'b1;
    end else begin
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(8, 40);
      m_tready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_local.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected local time beat %h", $time, m_tdata);
      end else begin
        oldest_local = pending_local.pop_front();
        beats_checked++;
        if (oldest_local.dst_applied) summer_beats++;
        for (int i = 0; i < 8; i++) begin
          if (field_of(m_tdata, i) !== field_of(oldest_local, i)) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: %s expected %0d got %0d", $time, field_name(i),
                       field_of(oldest_local, i), field_of(m_tdata, i));
            end
          end
        end
      end
    end
  end

  // reset values: no offset, summer time off
  task automatic test_reset_defaults();
    send_utc(utc_at(30, 15, 12, 15, 6, 2024, 2));
    send_utc(utc_at(0, 0, 0, 1, 1, 1970, 3));
  endtask

  task automatic test_field_extremes();
    configure(14, 0);
    send_utc(utc_at(63, 63, 31, 31, 15, 4095, 7));
    send_utc(utc_at(0, 0, 0, 0, 0, 0, 0));
    configure(-12, 0);
    send_utc(utc_at(63, 63, 31, 31, 15, 4095, 7));
    send_utc(utc_at(0, 0, 0, 0, 0, 0, 0));
    configure(-16, 0);
    send_utc(utc_at(0, 0, 0, 0, 0, 0, 0));
    configure(15, 0);
    send_utc(utc_at(63, 63, 31, 31, 15, 4095, 7));
  endtask

  task automatic test_day_carries();
    configure(14, 0);
    send_utc(utc_at(0, 0, 20, 31, 12, 2225, 6));
    send_utc(utc_at(0, 0, 12, 28, 2, 2024, 2));
    send_utc(utc_at(0, 0, 12, 28, 2, 2100, 0));
    send_utc(utc_at(0, 0, 12, 29, 2, 2000, 1));
    send_utc(utc_at(0, 0, 12, 31, 4, 2023, 1));
    configure(-12, 0);
    send_utc(utc_at(0, 0, 5, 1, 1, 1970, 3));
    send_utc(utc_at(0, 0, 5, 1, 3, 2024, 4));
    send_utc(utc_at(0, 0, 5, 1, 3, 2200, 4));
  endtask

  task automatic test_summer_switch();
    configure(0, 1);
    send_utc(utc_at(0, 0, 1, 31, 3, 2024, 6));
    send_utc(utc_at(0, 0, 3, 31, 3, 2024, 6));
    send_utc(utc_at(0, 0, 12, 24, 3, 2030, 6));
    send_utc(utc_at(0, 0, 12, 25, 3, 2030, 5));
    send_utc(utc_at(0, 0, 12, 31, 3, 2030, 5));
    send_utc(utc_at(0, 0, 2, 27, 10, 2024, 6));
    send_utc(utc_at(0, 0, 3, 27, 10, 2024, 6));
    send_utc(utc_at(0, 0, 23, 30, 9, 2024, 0));
    configure(14, 1);
    send_utc(utc_at(0, 0, 9, 31, 10, 2024, 3));
  endtask

  task automatic test_random_settings(input int items);
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: configure(0, 0);
        1: configure(-12, 1);
        2: configure(14, 1);
        3: configure(-16, 1);
        4: configure(15, 0);
        5: configure(1, 1);
        6: configure(2, 1);
        7: configure(-1, 1);
        default: configure(int'($urandom_range(0, 26)) - 12, $urandom_range(0, 1));
      endcase
      gaps_off = (p % 4 == 3);
      for (int i = 0; i < items / 12; i++) send_utc(random_utc());
    end
    gaps_off = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_field_extremes();
    test_day_carries();
    test_summer_switch();
    test_random_settings(1428);
    settle();
    $display("checked %0d local time beats over %0d register settings", beats_checked,
             settings_used);
    $display("%0d beats had summer time applied, %0d mismatches", summer_beats, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/utcl_pkg.sv
src/utcl_offset_stage.sv
src/utcl_dst_stage.sv
src/utc_to_local_time_eu_dst_core.sv
bench/utc_to_local_time_eu_dst_core_test.sv
